// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
// Each macro takes a label, the clock, the reset, the property and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== hdl/cesd_pkg.sv =====
`default_nettype none

package cesd_pkg;

  localparam int CharW = 8;
  localparam int DigitCntW = 2;
  localparam int CmdDepthDefault = 4;

  localparam logic [DigitCntW-1:0] OctalMaxDigits = 2'd3;

  localparam logic [CharW-1:0] CharBackslash = 8'h5C;
  localparam logic [CharW-1:0] CharN = 8'h6E;
  localparam logic [CharW-1:0] CharT = 8'h74;
  localparam logic [CharW-1:0] CharB = 8'h62;
  localparam logic [CharW-1:0] CharR = 8'h72;
  localparam logic [CharW-1:0] CharF = 8'h66;

  localparam logic [CharW-1:0] CodeLf = 8'h0A;
  localparam logic [CharW-1:0] CodeHt = 8'h09;
  localparam logic [CharW-1:0] CodeBs = 8'h08;
  localparam logic [CharW-1:0] CodeCr = 8'h0D;
  localparam logic [CharW-1:0] CodeFf = 8'h0C;

  // One queued command: one or two decoded bytes caused by a single input.
  typedef struct packed {
    logic [CharW-1:0] first_char;
    logic [CharW-1:0] second_char;
    logic             two;
    logic             fin;
  } cmd_t;

  function automatic logic is_octal(input logic [CharW-1:0] c);
    return c[7:3] == 5'b00110;
  endfunction

  function automatic logic [CharW-1:0] map_escape(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    unique case (c)
      CharN:   r = CodeLf;
      CharT:   r = CodeHt;
      CharB:   r = CodeBs;
      CharR:   r = CodeCr;
      CharF:   r = CodeFf;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cesd_front.sv =====
`default_nettype none

module cesd_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [cesd_pkg::CharW-1:0] in_char,
  input  wire logic                     is_final,
  output logic                          push,
  output cesd_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2
  } mode_t;

  mode_t                          mode, mode_next;
  logic [cesd_pkg::CharW-1:0]     accum, accum_next;
  logic [cesd_pkg::DigitCntW-1:0] digits, digits_next;
  logic                           emit;

  logic [cesd_pkg::CharW-1:0]     acc_step;
  logic [cesd_pkg::DigitCntW-1:0] dig_step;
  logic [cesd_pkg::CharW-1:0]     oct_val;
  logic                           c_octal;
  logic                           c_bslash;

  assign c_octal  = cesd_pkg::is_octal(in_char);
  assign c_bslash = (in_char == cesd_pkg::CharBackslash);
  assign oct_val  = {5'b00000, in_char[2:0]};
  assign acc_step = {accum[4:0], in_char[2:0]};
  assign dig_step = digits + 2'd1;

  always_comb begin
    mode_next       = MODE_NORMAL;
    accum_next      = accum;
    digits_next     = digits;
    emit            = 1'b0;
    cmd.first_char  = in_char;
    cmd.second_char = in_char;
    cmd.two         = 1'b0;
    cmd.fin         = is_final;
    unique case (mode)
      MODE_ESCAPE: begin
        if (c_octal) begin
          accum_next  = oct_val;
          digits_next = 2'd1;
          if (is_final) begin
            emit           = 1'b1;
            cmd.first_char = oct_val;
          end else begin
            mode_next = MODE_OCTAL;
          end
        end else begin
          emit           = 1'b1;
          cmd.first_char = cesd_pkg::map_escape(in_char);
        end
      end
      MODE_OCTAL: begin
        if (c_octal && (digits < cesd_pkg::OctalMaxDigits)) begin
          accum_next  = acc_step;
          digits_next = dig_step;
          if (is_final || (dig_step == cesd_pkg::OctalMaxDigits)) begin
            emit           = 1'b1;
            cmd.first_char = acc_step;
          end else begin
            mode_next = MODE_OCTAL;
          end
        end else begin
          // The run ends: its byte goes out, then the ending byte decodes plainly.
          emit           = 1'b1;
          cmd.first_char = accum;
          if (c_bslash && !is_final) begin
            mode_next = MODE_ESCAPE;
          end else begin
            cmd.two = 1'b1;
          end
        end
      end
      default: begin
        if (c_bslash && !is_final) begin
          mode_next = MODE_ESCAPE;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (is_final) begin
      mode_next   = MODE_NORMAL;
      accum_next  = '0;
      digits_next = '0;
    end else if (mode_next != MODE_OCTAL) begin
      accum_next  = '0;
      digits_next = '0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      accum  <= '0;
      digits <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      accum  <= accum_next;
      digits <= digits_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cesd_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"

module cesd_fifo #(
  parameter int Depth = cesd_pkg::CmdDepthDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cesd_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output cesd_pkg::cmd_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cesd_pkg::cmd_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, push && full, "command pushed into a full queue")
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && !head_valid, "command popped from an empty queue")
  `ASSERT_ALWAYS(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count did not follow a lone push")

endmodule

`default_nettype wire

// ===== hdl/cesd_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module cesd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       head_valid,
  input  wire cesd_pkg::cmd_t             head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [cesd_pkg::CharW-1:0]      m_tdata,
  output logic                            m_tlast,
  output logic                            m_tuser
);

  logic sel;
  logic load;
  logic last_of_cmd;

  assign load        = !m_tvalid || m_tready;
  assign last_of_cmd = sel || !head.two;
  assign pop         = load && head_valid && last_of_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 1'b0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        sel <= !last_of_cmd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      m_tdata <= sel ? head.second_char : head.first_char;
      m_tlast <= last_of_cmd;
      m_tuser <= last_of_cmd && head.fin;
    end
  end

  `ASSERT_ALWAYS(a_sel_needs_pair, clk, rst, sel |-> (head_valid && head.two), "second byte selected without a paired command")

endmodule

`default_nettype wire

// ===== hdl/c_escape_sequence_decoder_core.sv =====
`default_nettype none

// C backslash escape decoder. Raw string bytes enter on the slave stream, one
// transaction per byte, with s_tlast marking the final byte of a string. Plain
// bytes pass through; a backslash followed by n, t, b, r or f yields LF, HT,
// BS, CR or FF, and any other byte after a backslash stands for itself. One to
// three octal digits after a backslash build one byte (wrapping to 8 bits); a
// non-octal byte ends the run, the built byte goes out, and the ending byte is
// then decoded normally, so one input can cause two output bytes, and a
// backslash that opens an escape causes none. A lone backslash at the end of a
// string is emitted as a backslash, and every string starts in a clean state.
// On the master stream m_tlast marks the last output byte caused by one input
// transaction and m_tuser marks the final decoded byte of the string. The
// input side takes one transaction per cycle as long as the command queue
// (CmdDepth entries) has room; the output side delivers one byte per cycle
// while m_tready is high, so an input that causes two bytes holds the back
// end for both; the queue absorbs that and pushes back on the input only when
// it is full. Each byte passes through a queue entry and an output register.
module c_escape_sequence_decoder_core #(
  parameter int CmdDepth = cesd_pkg::CmdDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input stream.
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_char
  input  wire logic       s_tlast,   // is_final
  // Output stream.
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic            m_tlast,   // run_last
  output logic            m_tuser    // [0] string_end
);

  logic           accept;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  cesd_pkg::cmd_t cmd;
  cesd_pkg::cmd_t head;

  // The front end only needs a free queue slot; it never waits on the output.
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  cesd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_char  (s_tdata),
    .is_final (s_tlast),
    .push     (push),
    .cmd      (cmd)
  );

  cesd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end walks each command one byte per transaction into a
  // registered output stage.
  cesd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ===== test/escape_decode_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of the escape decoder, predicts the decoded bytes
// from each accepted input transaction and compares every output transaction
// with the oldest prediction.
module escape_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic       m_tuser,
  output int         fail_count,
  output int         decoded_pending
);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSeven = 8'h37;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEscape = 2'd1,
    ModeOctal  = 2'd2
  } decode_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       string_end;
  } decoded_byte_t;

  decode_mode_t  esc_mode = ModeNormal;
  logic [7:0]    octal_value = '0;
  logic [1:0]    octal_count = '0;
  decoded_byte_t decoded_queue[$];
  int            mismatch_count = 0;
  int            queue_depth = 0;

  assign fail_count      = mismatch_count;
  assign decoded_pending = queue_depth;

  function automatic logic is_octal_digit(input logic [7:0] c);
    return c >= CharZero && c <= CharSeven;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Advances the decoder state by one raw byte and queues the bytes it yields.
  task automatic decode_raw_byte(input logic [7:0] c, input logic fin);
    logic [7:0]    outs [0:1];
    int            n;
    logic          take_plain;
    decoded_byte_t item;
    n = 0;
    take_plain = 1'b0;
    case (esc_mode)
      ModeEscape: begin
        esc_mode = ModeNormal;
        if (is_octal_digit(c)) begin
          octal_value = c - CharZero;
          octal_count = 2'd1;
          if (fin) begin
            outs[n] = octal_value;
            n++;
          end else begin
            esc_mode = ModeOctal;
          end
        end else begin
          case (c)
            cesd_pkg::CharN: outs[n] = cesd_pkg::CodeLf;
            cesd_pkg::CharT: outs[n] = cesd_pkg::CodeHt;
            cesd_pkg::CharB: outs[n] = cesd_pkg::CodeBs;
            cesd_pkg::CharR: outs[n] = cesd_pkg::CodeCr;
            cesd_pkg::CharF: outs[n] = cesd_pkg::CodeFf;
            default:         outs[n] = c;
          endcase
          n++;
        end
      end
      ModeOctal: begin
        if (is_octal_digit(c) && octal_count < cesd_pkg::OctalMaxDigits) begin
          octal_value = {octal_value[4:0], 3'b000} + (c - CharZero);
          octal_count = octal_count + 2'd1;
          if (fin || octal_count >= cesd_pkg::OctalMaxDigits) begin
            outs[n] = octal_value;
            n++;
            esc_mode = ModeNormal;
          end
        end else begin
          // The ending byte flushes the run and is then decoded as usual.
          outs[n] = octal_value;
          n++;
          esc_mode = ModeNormal;
          take_plain = 1'b1;
        end
      end
      default: begin
        esc_mode = ModeNormal;
        take_plain = 1'b1;
      end
    endcase
    if (take_plain) begin
      if (c == cesd_pkg::CharBackslash && !fin) begin
        esc_mode = ModeEscape;
      end else begin
        outs[n] = c;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      item.ch         = outs[k];
      item.run_last   = (k == n - 1);
      item.string_end = (k == n - 1) && fin;
      decoded_queue.push_back(item);
    end
    if (fin) begin
      esc_mode    = ModeNormal;
      octal_value = '0;
      octal_count = '0;
    end else if (esc_mode != ModeOctal) begin
      octal_value = '0;
      octal_count = '0;
    end
  endtask

  always @(posedge clk) begin : watch_p
    decoded_byte_t want;
    if (rst) begin
      esc_mode    = ModeNormal;
      octal_value = '0;
      octal_count = '0;
      decoded_queue.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        decode_raw_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (decoded_queue.size() == 0) begin
          report_mismatch("unexpected output byte", m_tdata, 8'h00);
        end else begin
          want = decoded_queue.pop_front();
          if (m_tdata !== want.ch) begin
            report_mismatch("out_char", m_tdata, want.ch);
          end
          if (m_tlast !== want.run_last) begin
            report_mismatch("run_last", {7'd0, m_tlast}, {7'd0, want.run_last});
          end
          if (m_tuser !== want.string_end) begin
            report_mismatch("string_end", {7'd0, m_tuser}, {7'd0, want.string_end});
          end
        end
      end
    end
    queue_depth = decoded_queue.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;
  int         fail_count;
  int         decoded_pending;

  // Chance, in percent, that the sender idles or the receiver stalls, drawn each cycle.
  int send_idle_pct = 0;
  int ready_stall_pct = 0;

  // Directed strings, one entry per input transaction as {is_final, in_char}.
  localparam int DirectedCount = 29;
  logic [8:0] directed_items [DirectedCount] = '{
    // Both extremes of the byte, zero byte is an ordinary character.
    {1'b0, 8'h00}, {1'b1, 8'hFF},
    // Every control escape.
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, cesd_pkg::CharN},
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, cesd_pkg::CharT},
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, cesd_pkg::CharB},
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, cesd_pkg::CharR},
    {1'b0, cesd_pkg::CharBackslash}, {1'b1, cesd_pkg::CharF},
    // Any other escaped character stands for itself.
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, 8'h71},
    // Three octal digits complete a run; 0777 wraps to 0xFF.
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, 8'h37}, {1'b0, 8'h37}, {1'b0, 8'h37},
    // A non-octal byte ends a run and yields two bytes on the final byte.
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, 8'h31}, {1'b0, 8'h32}, {1'b1, 8'h78},
    // A run ended by a trailing backslash also yields two bytes.
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, 8'h31}, {1'b1, cesd_pkg::CharBackslash},
    // A lone backslash as the whole string.
    {1'b1, cesd_pkg::CharBackslash},
    // The string ends inside an octal run.
    {1'b0, cesd_pkg::CharBackslash}, {1'b0, 8'h34}, {1'b1, 8'h35}
  };

  c_escape_sequence_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  escape_decode_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .decoded_pending (decoded_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver decides each cycle whether to stall.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // Offers one byte and returns at the falling edge after its transaction.
  // The valid stays high so that back-to-back bytes carry no gap.
  task automatic send_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted byte has come out.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (decoded_pending != 0) @(negedge clk);
  endtask

  // Byte mix weighted toward backslashes and octal digits so that escapes,
  // octal runs of every length and their endings occur often.
  task automatic send_random_bytes(input int count);
    int         pick;
    logic [7:0] c;
    logic       fin;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        c = cesd_pkg::CharBackslash;
      end else if (pick < 55) begin
        c = 8'h30 + 8'($urandom_range(0, 7));
      end else if (pick < 65) begin
        case ($urandom_range(0, 4))
          0: c = cesd_pkg::CharN;
          1: c = cesd_pkg::CharT;
          2: c = cesd_pkg::CharB;
          3: c = cesd_pkg::CharR;
          default: c = cesd_pkg::CharF;
        endcase
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      fin = ($urandom_range(0, 7) == 0) || (i == count - 1);
      send_byte(c, fin);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed strings and then random ones, with no idling on either side.
    for (int i = 0; i < DirectedCount; i++) begin
      send_byte(directed_items[i][7:0], directed_items[i][8]);
    end
    send_random_bytes(225);
    drain();

    send_idle_pct = 87;
    ready_stall_pct = 0;
    send_random_bytes(225);
    drain();

    send_idle_pct = 0;
    ready_stall_pct = 87;
    send_random_bytes(225);
    drain();

    send_idle_pct = 38;
    ready_stall_pct = 38;
    send_random_bytes(225);
    drain();

    // Waiting on with the receiver ready catches any byte the block would add on its own.
    ready_stall_pct = 0;
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
